@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/q2e_pkg.sv @@
// shared types, constants and tables for the quaternion to euler block
package q2e_pkg;
  localparam int ANG_W = 40;
  localparam int ROOT_W = 62;
  localparam int TABLE_LEN = 24;
  localparam logic signed [ANG_W-1:0] ANG_90 = 40'sd754974720;
  localparam logic signed [14:0] PITCH_LIMIT = 15'sd11520;

  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic ang_t atan_entry(input int idx);
    ang_t r;
    case (idx)
      0: r = 40'sd377487360;
      1: r = 40'sd222843801;
      2: r = 40'sd117744544;
      3: r = 40'sd59768969;
      4: r = 40'sd30000467;
      5: r = 40'sd15014858;
      6: r = 40'sd7509261;
      7: r = 40'sd3754860;
      8: r = 40'sd1877459;
      9: r = 40'sd938733;
      10: r = 40'sd469367;
      11: r = 40'sd234683;
      12: r = 40'sd117342;
      13: r = 40'sd58671;
      14: r = 40'sd29335;
      15: r = 40'sd14668;
      16: r = 40'sd7334;
      17: r = 40'sd3667;
      18: r = 40'sd1833;
      19: r = 40'sd917;
      20: r = 40'sd458;
      21: r = 40'sd229;
      22: r = 40'sd115;
      23: r = 40'sd57;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/quaternion_to_euler_angles.sv @@
// the pitch path with its 31 sqrt stages sets the latency; yaw and roll operands are delayed to match it
// throughput: one quaternion per clock while the skid stage is empty, every stage is a registered cell
// reset clears the valid pipeline and the output flags; payload registers are not reset
// output register with a skid stage; the whole pipe stalls while the skid holds a result
module quaternion_to_euler_angles import q2e_pkg::*; #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // yaw_angle, pitch_angle, roll_angle, pad 1 bit
  output logic        m_axis_tuser   // pitch_clamped
);
  localparam int VW = 66;
  localparam int F2 = 2*QUAT_FRAC_BITS;
  localparam int SQ = 31;
  localparam int CN = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int LAT = 2 + SQ + 1 + CN + 1;
  localparam int ALAT = CN + 2;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< F2;

  logic adv;

  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  // stage 1: products
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz, p_wx, p_yz, p_xx, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_wz <= qw*qz; p_xy <= qx*qy; p_yy <= qy*qy; p_zz <= qz*qz;
      p_wx <= qw*qx; p_yz <= qy*qz; p_xx <= qx*qx; p_wy <= qw*qy; p_zx <= qz*qx;
    end
  end

  // stage 2: sums
  logic signed [VW-1:0] yaw_y, yaw_x, rol_y, rol_x, sinp;
  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_y <= VW'(p_wz) + VW'(p_xy) <<< 1;
      yaw_x <= ONE - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
      rol_y <= VW'(p_wx) + VW'(p_yz) <<< 1;
      rol_x <= ONE - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
      sinp  <= (VW'(p_wy) - VW'(p_zx)) <<< 1;
    end
  end

  // stage 3: clamp check, scale to 30 fraction bits, square
  logic signed [VW-1:0] s_sc;
  logic [1:0] clamp3;
  logic signed [VW-1:0] s3;
  logic [ROOT_W-1:0] sq_in;
  logic [30:0] mag;
  always_comb begin
    if (F2 >= 30) s_sc = sinp >>> (F2 - 30);
    else s_sc = sinp <<< (30 - F2);
  end
  assign mag = s_sc[VW-1] ? 31'(-s_sc) : 31'(s_sc);
  always_ff @(posedge clk) begin
    if (adv) begin
      clamp3 <= {sinp <= -ONE, sinp >= ONE};
      s3 <= s_sc;
      sq_in <= ROOT_W'((64'd1 << 60) - 64'(mag) * 64'(mag));
    end
  end

  // sqrt chain of cells
  logic [ROOT_W-1:0] rem [0:SQ];
  logic [ROOT_W-1:0] res [0:SQ];
  logic signed [VW-1:0] sd [0:SQ];
  logic [1:0] cd [0:SQ+ALAT];
  assign rem[0] = sq_in;
  assign res[0] = '0;
  assign sd[0] = s3;
  assign cd[0] = clamp3;
  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(i)) u_sq (
      .clk(clk), .en(adv), .rem_in(rem[i]), .res_in(res[i]),
      .rem_out(rem[i+1]), .res_out(res[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) sd[i+1] <= sd[i];
    end
  end
  for (genvar i = 0; i < SQ+ALAT; i++) begin : g_cd
    always_ff @(posedge clk) begin
      if (adv) cd[i+1] <= cd[i];
    end
  end

  logic signed [15:0] pitch_raw, yaw_raw, rol_raw;
  q2e_atan2 #(.VW(VW), .STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(adv), .y_in(sd[SQ]), .x_in(VW'(res[SQ])), .angle(pitch_raw)
  );

  // delay yaw and roll operands to line up with pitch
  logic signed [VW-1:0] dyy [0:SQ+1], dyx [0:SQ+1], dry [0:SQ+1], drx [0:SQ+1];
  assign dyy[0] = yaw_y; assign dyx[0] = yaw_x;
  assign dry[0] = rol_y; assign drx[0] = rol_x;
  for (genvar i = 0; i < SQ+1; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (adv) begin
        dyy[i+1] <= dyy[i]; dyx[i+1] <= dyx[i];
        dry[i+1] <= dry[i]; drx[i+1] <= drx[i];
      end
    end
  end
  q2e_atan2 #(.VW(VW), .STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(adv), .y_in(dyy[SQ+1]), .x_in(dyx[SQ+1]), .angle(yaw_raw)
  );
  q2e_atan2 #(.VW(VW), .STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(adv), .y_in(dry[SQ+1]), .x_in(drx[SQ+1]), .angle(rol_raw)
  );

  logic [14:0] pitch_f;
  logic clamp_f;
  always_comb begin
    clamp_f = |cd[SQ+ALAT];
    case (cd[SQ+ALAT])
      2'b01: pitch_f = PITCH_LIMIT;
      2'b10: pitch_f = -PITCH_LIMIT;
      default: pitch_f = pitch_raw[14:0];
    endcase
  end

  // valid pipeline with stall; whole pipe advances while the skid is empty
  logic [LAT:0] vld;
  logic [47:0] res_data;
  logic        res_user;
  assign res_data = {1'b0, rol_raw, pitch_f, yaw_raw};
  assign res_user = clamp_f;

  logic [48:0] out_q, skid_q;
  logic out_vld, skid_vld, take, pop;
  assign adv = !skid_vld;
  assign s_axis_tready = adv;
  assign take = adv && vld[LAT];
  assign pop = out_vld && m_axis_tready;
  assign m_axis_tvalid = out_vld;
  assign {m_axis_tuser, m_axis_tdata} = out_q;

  // valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:0], s_axis_tvalid && s_axis_tready};
    end
  end

  // output and skid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0; skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (pop) skid_vld <= 1'b0;
    end else if (take) begin
      if (!out_vld || pop) out_vld <= 1'b1;
      else skid_vld <= 1'b1;
    end else if (pop) begin
      out_vld <= 1'b0;
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (pop) out_q <= skid_q;
    end else if (take) begin
      if (!out_vld || pop) out_q <= {res_user, res_data};
      else skid_q <= {res_user, res_data};
    end
  end
endmodule

@@ rtl/q2e_cordic_cell.sv @@
// one vectoring cordic iteration stage with registered outputs
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int VW = 64,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  input  ang_t                 acc_in,
  output logic signed [VW-1:0] x_out,
  output logic signed [VW-1:0] y_out,
  output ang_t                 acc_out
);
  logic signed [VW-1:0] xs, ys;
  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  // rotate toward the x axis by the sign of y
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out   <= x_in + ys;
        y_out   <= y_in - xs;
        acc_out <= acc_in + atan_entry(STEP);
      end else begin
        x_out   <= x_in - ys;
        y_out   <= y_in + xs;
        acc_out <= acc_in - atan_entry(STEP);
      end
    end
  end
endmodule

@@ rtl/q2e_sqrt_cell.sv @@
// one stage of a restoring square root, one result bit per stage
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W-1:0] rem_in,
  input  logic [ROOT_W-1:0] res_in,
  output logic [ROOT_W-1:0] rem_out,
  output logic [ROOT_W-1:0] res_out
);
  localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (60 - 2*STEP);
  logic [ROOT_W-1:0] trial;
  assign trial = res_in + BIT;

  // subtract trial when it fits, shift the partial root
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        res_out <= (res_in >> 1) + BIT;
      end else begin
        rem_out <= rem_in;
        res_out <= res_in >> 1;
      end
    end
  end
endmodule

@@ rtl/q2e_atan2.sv @@
// atan2 as a pre-rotation stage, a row of cordic cells and a rounding stage
module q2e_atan2 import q2e_pkg::*; #(
  parameter int VW = 64,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] y_in,
  input  logic signed [VW-1:0] x_in,
  output logic signed [15:0]   angle
);
  localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  logic signed [VW-1:0] xr [0:N];
  logic signed [VW-1:0] yr [0:N];
  ang_t ar [0:N];
  logic zr [0:N];

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0 && y_in >= 0) begin
        xr[0] <= y_in; yr[0] <= -x_in; ar[0] <= ANG_90;
      end else if (x_in < 0) begin
        xr[0] <= -y_in; yr[0] <= x_in; ar[0] <= -ANG_90;
      end else begin
        xr[0] <= x_in; yr[0] <= y_in; ar[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    q2e_cordic_cell #(.VW(VW), .STEP(i)) u_cell (
      .clk(clk), .en(en), .x_in(xr[i]), .y_in(yr[i]), .acc_in(ar[i]),
      .x_out(xr[i+1]), .y_out(yr[i+1]), .acc_out(ar[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) zr[i+1] <= zr[i];
    end
  end

  ang_t rounded;
  assign rounded = (ar[N] + ang_t'(32768)) >>> 16;

  // round half up to 1/128 degree, zero vector gives zero
  always_ff @(posedge clk) begin
    if (en) angle <= zr[N] ? 16'sd0 : rounded[15:0];
  end
endmodule

@@ rtl/q2e_checker.sv @@
// port-level checks of the quaternion to euler block
`include "assert_macros.svh"
module q2e_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_pitch_clamp, clk, rst, m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[30:16] == 15'd11520 || m_axis_tdata[30:16] == 15'h5300), "clamped pitch not at limit")
  `ASSERT_CLK(a_pad_zero, clk, rst, m_axis_tvalid |-> !m_axis_tdata[47], "pad bit set")
  `ASSERT_CLK(a_ready_known, clk, rst, s_axis_tvalid |-> !$isunknown(s_axis_tready), "input ready unknown")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result after reset")
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

@@ verif/tb_quaternion_to_euler_angles.sv @@
// testbench for the quaternion to euler angle converter: directed and random quaternions
module tb_quaternion_to_euler_angles;
  timeunit 1ns;
  timeprecision 1ps;
  import q2e_pkg::*;

  localparam int FRAC = 14;
  localparam int STEPS = 16;
  localparam int LATENCY = 4 + STEPS + 31 + 2;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
    logic        clamped;
  } angles_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  angles_t expected_angles[$];
  int      mismatch_count = 0;
  longint  cycle_count = 0;
  bit      quiet_sender = 1'b0;
  bit      quiet_receiver = 1'b0;
  int      hold_off_cycles = 0;
  int      stall_left = 0;

  quaternion_to_euler_angles #(.QUAT_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // floor division by a power of two
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // vectoring rotation, angle in degrees*128 rounded half up
  function automatic longint vector_angle(longint ya, longint xa);
    longint acc, t, xs, ys;
    acc = 0;
    if (xa == 0 && ya == 0) return 0;
    if (xa < 0) begin
      if (ya >= 0) begin
        t = xa; xa = ya; ya = -t; acc = longint'(ANG_90);
      end else begin
        t = xa; xa = -ya; ya = t; acc = -longint'(ANG_90);
      end
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      xs = floor_shift(xa, i);
      ys = floor_shift(ya, i);
      if (ya > 0) begin
        xa = xa + ys; ya = ya - xs; acc += longint'(atan_entry(i));
      end else begin
        xa = xa - ys; ya = ya + xs; acc -= longint'(atan_entry(i));
      end
    end
    return floor_shift(acc + (64'sd1 <<< 15), 16);
  endfunction

  function automatic angles_t predict_angles(logic [63:0] q);
    longint w, x, y, z, one, sinp, s, pitch;
    longint unsigned mag;
    angles_t r;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    one = 64'sd1 <<< (2 * FRAC);
    r.yaw = 16'(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
    r.roll = 16'(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
    sinp = 2 * (w * y - z * x);
    r.clamped = 1'b0;
    if (sinp >= one) begin
      pitch = longint'(PITCH_LIMIT); r.clamped = 1'b1;
    end else if (sinp <= -one) begin
      pitch = -longint'(PITCH_LIMIT); r.clamped = 1'b1;
    end else begin
      if (2 * FRAC >= 30) s = floor_shift(sinp, 2 * FRAC - 30);
      else s = sinp * (64'sd1 <<< (30 - 2 * FRAC));
      mag = longint'(s < 0 ? -s : s);
      pitch = vector_angle(s, longint'(int_sqrt((64'd1 << 60) - mag * mag)));
    end
    r.pitch = 15'(pitch);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // send one request, holding tvalid until it is taken
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    int gap;
    if (!quiet_sender && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x, w};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_angles.push_back(predict_angles({z, y, x, w}));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // random quaternion scaled close to unit length
  task automatic send_unit_quat();
    real a, b, c, d, n;
    a = $signed($urandom_range(0, 2000)) - 1000;
    b = $signed($urandom_range(0, 2000)) - 1000;
    c = $signed($urandom_range(0, 2000)) - 1000;
    d = $signed($urandom_range(0, 2000)) - 1000;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
              16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
  endtask

  task automatic test_directed();
    logic [15:0] p, m, h;
    p = 16'sd16384; m = -16'sd16384; h = 16'sd11585;
    send_quat(p, 0, 0, 0);
    send_quat(m, 0, 0, 0);
    send_quat(0, p, 0, 0);
    send_quat(0, 0, p, 0);
    send_quat(0, 0, 0, p);
    send_quat(0, 0, 0, 0);
    // near gimbal lock both ways; pitch stays just inside the clamp limit
    send_quat(h, 0, h, 0);
    send_quat(h, 0, m ^ 16'h0000 ? -h : -h, 0);
    send_quat(h, h, h, h);
    send_quat(h, -h, h, h);
    send_quat(p, p, p, p);
    send_quat(m, m, m, m);
    send_quat(p, m, p, m);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_quat(0, 0, 0, 1);
    send_quat(0, 0, 0, -1);
    send_quat(0, h, h, 0);
    send_quat(16000, 0, 3500, 0);
    send_quat(16000, 0, -3500, 0);
    stop_sending();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      else if ($urandom_range(0, 9) == 0)
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_unit_quat();
    end
    stop_sending();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_backpressure();
    hold_off_cycles = 3 * LATENCY;
    test_random(150);
  endtask

  task automatic test_full_rate(int n);
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    test_random(n);
  endtask

  // receiver ready: random stall bursts, long hold off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_receiver && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    angles_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tdata[46:31], m_axis_tuser};
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_angles.pop_front();
        if (got.yaw !== want.yaw)
          report_mismatch("yaw", $signed(got.yaw), $signed(want.yaw));
        if (got.pitch !== want.pitch)
          report_mismatch("pitch", $signed(got.pitch), $signed(want.pitch));
        if (got.roll !== want.roll)
          report_mismatch("roll", $signed(got.roll), $signed(want.roll));
        if (got.clamped !== want.clamped)
          report_mismatch("clamp", got.clamped, want.clamped);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("quaternion_to_euler_angles regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(800);
    test_backpressure();
    test_full_rate(700);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_angles.size() == 0)
      $display("quaternion_to_euler_angles regression: pass");
    else
      $display("quaternion_to_euler_angles regression: fail");
    $finish;
  end
endmodule
